### src/gmcs_pkg.sv
// ----------------------------------------------------------------------------
// gmcs_pkg
// Shared types and constants for the greedy maximum-count selector.
// ----------------------------------------------------------------------------
package gmcs_pkg;

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 12;
    localparam int CFG_W   = 11;

    // Reset value of the scan length register.
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

    // Saturation floor of a count and the value written to a picked entry.
    localparam logic [COUNT_W-1:0] COUNT_MIN    = 12'h800;
    localparam logic [COUNT_W-1:0] COUNT_MARKED = 12'hFFF;

    // Item operations.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_SELECT = 2'd2,
        OP_DEC    = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_PUSH,
        S_QPOP,
        S_SCAN,
        S_SDRAIN,
        S_MARK,
        S_DREAD,
        S_DWRITE,
        S_RESULT
    } t_state;

endpackage

### src/gmcs_ram.sv
// ----------------------------------------------------------------------------
// gmcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/gmcs_fifo.sv
// ----------------------------------------------------------------------------
// gmcs_fifo
// Queue of forced picks. The head entry is read continuously, so its data is
// valid in the cycle after the head pointer settles.
// ----------------------------------------------------------------------------
module gmcs_fifo
    import gmcs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_pop,
    input  logic [IDX_W-1:0] i_wdata,
    output logic [IDX_W-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);

    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [PW:0]   r_count;

    // Storage for the queued indices.
    gmcs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_push),
        .i_waddr (r_tail),
        .i_wdata (i_wdata),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    // Pointers and occupancy; pointers wrap at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);

    // A pop on an empty queue would corrupt the occupancy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("pop while queue empty");

    // A push into a full queue would overwrite the head.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("push while queue full");

    // An empty queue has matching pointers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_empty |-> (r_head == r_tail))
        else $error("pointers differ while queue empty");

endmodule

### src/gmcs_scan.sv
// ----------------------------------------------------------------------------
// gmcs_scan
// Running maximum tracker fed one table entry per cycle. The first entry
// (index zero) restarts the search; ties keep the earlier index.
// ----------------------------------------------------------------------------
module gmcs_scan
    import gmcs_pkg::*;
#(
    parameter int AW = 10
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [AW-1:0]      i_index,
    input  logic [COUNT_W-1:0] i_data,
    output logic [AW-1:0]      o_best_index
);

    logic [COUNT_W-1:0] r_best;
    logic [AW-1:0]      r_best_index;
    logic               w_take;

    // Strictly greater wins, so the lowest index holds on a tie.
    assign w_take = (i_index == '0) || ($signed(i_data) > $signed(r_best));

    always_ff @(posedge i_clk) begin
        if (i_en && w_take) begin
            r_best       <= i_data;
            r_best_index <= i_index;
        end
    end

    assign o_best_index = r_best_index;

endmodule

### src/greedy_max_count_selector.sv
// ----------------------------------------------------------------------------
// greedy_max_count_selector
// Table of signed counts with a queue of forced picks. Select returns the
// queue head, or else the lowest index holding the largest count, and marks
// the chosen entry with -1.
//
//  Channel   Direction  Handshake                   Payload
//  in        sink       i_in_valid / o_in_ready     opcode, entry_index, count_value
//  out       source     o_out_valid / i_out_ready   selected_index, from_queue, status
//  cfg       sink       i_cfg_valid / o_cfg_ready   entries_in_use
//
// Load and push pass to the result state; decrement reads, then writes the
// entry; a select pops the queue head, or with an empty queue scans N entries,
// N being the scan length (one table entry per cycle), and then marks its pick.
// The result becomes valid in the same cycle that o_in_ready returns.
// A result that waits holds the sequencer until the output register is free.
// After reset a clearing pass zeroes all TABLE_SIZE entries, one per cycle.
// ----------------------------------------------------------------------------
module greedy_max_count_selector
    import gmcs_pkg::*;
#(
    parameter int TABLE_SIZE  = 1024,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Item input
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic [IDX_W-1:0]          i_entry_index,
    input  logic signed [COUNT_W-1:0] i_count_value,
    // Result output
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [IDX_W-1:0]          o_selected_index,
    output logic                      o_from_queue,
    output logic                      o_status,
    // Configuration write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int AW = $clog2(TABLE_SIZE);

    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [COUNT_W-1:0] r_val;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_pipe_addr;
    logic               r_pipe_valid;
    logic               r_from_q;
    logic               r_drop;
    logic [CFG_W-1:0]   r_entries;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_sel;
    logic               r_out_fq;
    logic               r_out_status;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_idx_ok;
    logic [AW-1:0]      w_last;
    logic [AW-1:0]      w_best;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [COUNT_W-1:0] w_ram_wdata;
    logic [AW-1:0]      w_ram_raddr;
    logic [COUNT_W-1:0] w_ram_rdata;
    logic               w_fifo_push;
    logic               w_fifo_pop;
    logic [IDX_W-1:0]   w_fifo_rdata;
    logic               w_fifo_full;
    logic               w_fifo_empty;
    logic               w_load_out;
    logic               w_scan_en;

    // Handshake terms.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_idx_ok    = (32'(r_idx) < TABLE_SIZE);

    // Last scanned address: zero entries scan entry 0, and the length is
    // clamped to the table size.
    always_comb begin
        if (r_entries == '0) begin
            w_last = '0;
        end else if (32'(r_entries) >= TABLE_SIZE) begin
            w_last = AW'(TABLE_SIZE - 1);
        end else begin
            w_last = AW'(r_entries - 11'd1);
        end
    end

    // Count table.
    gmcs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Forced pick queue.
    gmcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fifo_push),
        .i_pop   (w_fifo_pop),
        .i_wdata (r_idx),
        .o_rdata (w_fifo_rdata),
        .o_full  (w_fifo_full),
        .o_empty (w_fifo_empty)
    );

    // Compare unit, fed one entry per cycle, each in the cycle after its read.
    assign w_scan_en = r_pipe_valid;

    gmcs_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_en         (w_scan_en),
        .i_index      (r_pipe_addr),
        .i_data       (w_ram_rdata),
        .o_best_index (w_best)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == AW'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    unique case (t_op'(i_opcode))
                        OP_LOAD:   n_state = S_LOAD;
                        OP_PUSH:   n_state = S_PUSH;
                        OP_SELECT: n_state = w_fifo_empty ? S_SCAN : S_QPOP;
                        OP_DEC:    n_state = S_DREAD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD:   n_state = S_RESULT;
            S_PUSH:   n_state = S_RESULT;
            S_QPOP:   n_state = S_MARK;
            S_SCAN: begin
                if (r_addr == w_last) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: n_state = S_MARK;
            S_MARK:   n_state = S_RESULT;
            S_DREAD:  n_state = S_DWRITE;
            S_DWRITE: n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath controls per state.
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = AW'(r_idx);
        w_ram_wdata = r_val;
        w_ram_raddr = AW'(r_idx);
        w_fifo_push = 1'b0;
        w_fifo_pop  = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_addr;
                w_ram_wdata = '0;
            end
            S_LOAD: begin
                w_ram_we = w_idx_ok;
            end
            S_PUSH: begin
                w_fifo_push = !w_fifo_full;
            end
            S_QPOP: begin
                w_fifo_pop = 1'b1;
            end
            S_SCAN: begin
                w_ram_raddr = r_addr;
            end
            S_MARK: begin
                w_ram_we    = r_from_q ? w_idx_ok : 1'b1;
                w_ram_waddr = r_from_q ? AW'(r_idx) : w_best;
                w_ram_wdata = COUNT_MARKED;
            end
            S_DWRITE: begin
                w_ram_we    = w_idx_ok && (w_ram_rdata != COUNT_MIN);
                w_ram_wdata = w_ram_rdata - 12'd1;
            end
            S_RESULT: begin
                w_load_out = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_pipe_valid <= 1'b0;
            r_from_q     <= 1'b0;
            r_drop       <= 1'b0;
            r_entries    <= ENTRIES_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pipe_valid <= (r_state == S_SCAN);
            if (i_cfg_valid && o_cfg_ready) begin
                r_entries <= i_cfg_data;
            end
            if (w_in_xfer) begin
                r_addr   <= '0;
                r_from_q <= 1'b0;
                r_drop   <= 1'b0;
            end else if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_state == S_QPOP) begin
                r_from_q <= 1'b1;
            end
            if (r_state == S_PUSH) begin
                r_drop <= w_fifo_full;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item fields, queue head and result payload.
    always_ff @(posedge i_clk) begin
        r_pipe_addr <= r_addr;
        if (w_in_xfer) begin
            r_op  <= t_op'(i_opcode);
            r_idx <= i_entry_index;
            r_val <= i_count_value;
        end else if (r_state == S_QPOP) begin
            r_idx <= w_fifo_rdata;
        end
        if (w_load_out) begin
            r_out_sel    <= (r_op == OP_SELECT) ? (r_from_q ? r_idx : IDX_W'(w_best)) : '0;
            r_out_fq     <= (r_op == OP_SELECT) && r_from_q;
            r_out_status <= (r_op == OP_PUSH) && r_drop;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out_sel;
    assign o_from_queue     = r_out_fq;
    assign o_status         = r_out_status;

    // The compare unit only sees data from reads issued by the scan.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_valid |-> (r_state == S_SCAN || r_state == S_SDRAIN))
        else $error("compare unit fed outside a scan");

    // A result that cannot be handed over keeps the sequencer waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_out_valid && !i_out_ready) |=> (r_state == S_RESULT))
        else $error("result overwritten before transfer");

    // The scan never runs past the last entry in use.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= w_last))
        else $error("scan address beyond scan length");

    // No table write while waiting for an item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_ram_we)
        else $error("table written while idle");

endmodule
